// ===== design/sha1_pkg.sv =====
// SHA-1 digest package: shared types and constants.
// Used by the interfaces and every module of the digest block.
package sha1_pkg;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hefcdab89;
    localparam logic [31:0] H_INIT2 = 32'h98badcfe;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hc3d2e1f0;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
    } core_state_t;

endpackage

// ===== design/sha1_in_if.sv =====
// Input channel interface: valid/ready plus one input word.
// Depends on sha1_pkg.
interface sha1_in_if;
    import sha1_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/sha1_out_if.sv =====
// Output channel interface: valid/ready plus one digest word.
// Depends on sha1_pkg.
interface sha1_out_if;
    import sha1_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/sha1_front.sv =====
// Front part: two-entry queue of input words between the port and the core.
// Drops words that carry neither a byte nor an end mark. Depends on sha1_pkg.
module sha1_front (
    input  logic                clk,
    input  logic                rst_n,
    sha1_in_if.sink             in_ch,
    output sha1_pkg::in_word_t  q_data,
    output logic                q_valid,
    input  logic                q_pop
);
    import sha1_pkg::*;

    in_word_t  buf_reg [2];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic      push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready &&
                  (in_ch.data.byte_present || in_ch.data.end_of_message);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = buf_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_ch.data;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== design/sha1_core.sv =====
// Back part: block buffer, padding sequencer, one SHA-1 round per cycle,
// digest output register. Depends on sha1_pkg and sha1_out_if.
module sha1_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::in_word_t  q_data,
    input  logic                q_valid,
    output logic                q_pop,
    sha1_out_if.source          out_ch
);
    import sha1_pkg::*;

    core_state_t state_reg, state_next;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [31:0] blk_reg [16];  // block buffer, big-endian 32-bit words
    logic [60:0] total_reg;
    logic [6:0]  rnd_reg;
    logic [5:0]  pad_idx_reg;
    logic        final_reg;   // compression belongs to the final padding
    logic        second_reg;  // full block with end mark, or length-only block
    logic [2:0]  emit_reg;
    logic        ov_reg;
    out_word_t   od_reg;

    logic [31:0] f, k, t, nw, wcur;
    logic [5:0]  idx;
    logic        load_round;
    logic        blk_we;
    logic [5:0]  blk_widx;
    logic [7:0]  blk_wdata;

    assign idx = total_reg[5:0];

    // round function and message schedule
    always_comb
    begin
        nw = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wcur = (rnd_reg < 7'd16) ? w_reg[0] : {nw[30:0], nw[31]};
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wcur;
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        load_round = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_data.byte_present && idx == 6'd63)
                    begin
                        load_round = 1'b1;
                        state_next = ST_ROUND;
                    end
                    else if (q_data.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 7'd79)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (second_reg)
                begin
                    // length-only block done, or padding still to follow
                    state_next = (idx > 6'd55) ? ST_EMIT : ST_PAD;
                end
                else if (final_reg)
                begin
                    // no room for the length: one more block
                    state_next = (idx > 6'd55) ? ST_PAD : ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (pad_idx_reg == 6'd63)
                begin
                    load_round = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    if (emit_reg == 3'd5)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // block buffer write port: a message byte or the pad sweep
    always_comb
    begin
        blk_we    = 1'b0;
        blk_widx  = idx;
        blk_wdata = q_data.data_byte;
        if (state_reg == ST_IDLE && q_valid && q_data.byte_present)
        begin
            blk_we = 1'b1;
        end
        else if (state_reg == ST_PAD)
        begin
            blk_widx = pad_idx_reg;
            if (pad_idx_reg == idx && !second_reg)
            begin
                blk_we    = 1'b1;
                blk_wdata = PAD_BYTE;
            end
            else if (pad_idx_reg < idx && !second_reg)
            begin
                // message bytes stay in place
                blk_we = 1'b0;
            end
            else if (pad_idx_reg >= 6'd56 && (second_reg || idx < 6'd56))
            begin
                blk_we    = 1'b1;
                blk_wdata = 8'(({total_reg, 3'b000})
                    >> (6'd56 - {pad_idx_reg[2:0], 3'b000}));
            end
            else
            begin
                blk_we    = 1'b1;
                blk_wdata = 8'h00;
            end
        end
    end

    // block buffer: one byte lane written a cycle
    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_reg[blk_widx[5:2]][{~blk_widx[1:0], 3'b000} +: 8] <= blk_wdata;
        end
    end

    // working registers and schedule
    always_ff @(posedge clk)
    begin
        if (load_round)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= blk_reg[i];
            end
            // byte 63 is written on this same edge
            w_reg[15] <= {blk_reg[15][31:8], blk_wdata};
        end
        else if (state_reg == ST_ROUND)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wcur;
        end
    end

    // control, hash words, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            h_reg[0]    <= H_INIT0;
            h_reg[1]    <= H_INIT1;
            h_reg[2]    <= H_INIT2;
            h_reg[3]    <= H_INIT3;
            h_reg[4]    <= H_INIT4;
            total_reg   <= '0;
            rnd_reg     <= '0;
            pad_idx_reg <= '0;
            final_reg   <= 1'b0;
            second_reg  <= 1'b0;
            emit_reg    <= '0;
            ov_reg      <= 1'b0;
            od_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    rnd_reg <= '0;
                    pad_idx_reg <= '0;
                    emit_reg <= '0;
                    if (q_valid)
                    begin
                        if (q_data.byte_present)
                        begin
                            total_reg <= total_reg + 61'd1;
                        end
                        // a full buffer still needs padding after its compression
                        final_reg  <= q_data.end_of_message &&
                                      !(q_data.byte_present && idx == 6'd63);
                        second_reg <= q_data.end_of_message &&
                                      q_data.byte_present && idx == 6'd63;
                        if (q_data.end_of_message && !(q_data.byte_present &&
                            idx == 6'd63))
                        begin
                            second_reg <= 1'b0;
                        end
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                end
                ST_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    rnd_reg <= '0;
                    pad_idx_reg <= '0;
                    if (second_reg)
                    begin
                        if (idx <= 6'd55)
                        begin
                            // full block done, now the padding block
                            second_reg <= 1'b0;
                            final_reg  <= 1'b1;
                        end
                    end
                    else if (final_reg && idx > 6'd55)
                    begin
                        // length goes in an extra block
                        second_reg <= 1'b1;
                        final_reg  <= 1'b0;
                    end
                end
                ST_PAD:
                begin
                    pad_idx_reg <= pad_idx_reg + 6'd1;
                end
                ST_EMIT:
                begin
                    if (!ov_reg || out_ch.ready)
                    begin
                        if (emit_reg == 3'd5)
                        begin
                            h_reg[0]   <= H_INIT0;
                            h_reg[1]   <= H_INIT1;
                            h_reg[2]   <= H_INIT2;
                            h_reg[3]   <= H_INIT3;
                            h_reg[4]   <= H_INIT4;
                            total_reg  <= '0;
                            final_reg  <= 1'b0;
                            second_reg <= 1'b0;
                        end
                        else
                        begin
                            ov_reg <= 1'b1;
                            od_reg.digest_word <= h_reg[emit_reg];
                            od_reg.word_number <= emit_reg;
                            od_reg.last_word   <= (emit_reg == 3'd4);
                            emit_reg <= emit_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    rnd_reg <= '0;
                end
            endcase
        end
    end
endmodule

// ===== design/sha1_message_digest.sv =====
// SHA-1 digest over a byte stream, one round per cycle.
// Each message byte is stored in the block buffer; each full 64-byte block then
// runs 80 rounds and a hash add before further bytes are taken.
// End of message: each final block gets a pad sweep, then its rounds and add;
// then five digest words, one per cycle while the output is ready.
// Reset (async, active low) empties the queue and loads the initial hash values.
module sha1_message_digest (
    input  logic  clk,
    input  logic  rst_n,
    sha1_in_if.sink    in_ch,
    sha1_out_if.source out_ch
);
    import sha1_pkg::*;

    in_word_t q_data;
    logic     q_valid;
    logic     q_pop;

    sha1_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_data (q_data),
        .q_valid(q_valid),
        .q_pop  (q_pop)
    );

    sha1_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_data (q_data),
        .q_valid(q_valid),
        .q_pop  (q_pop),
        .out_ch (out_ch)
    );
endmodule
